// File: rtl/core/histeq_pkg.sv
// ----------------------------------------------------------------------------
// histeq_pkg
// Shared sizes, types and helpers of the histogram equalizer.
// ----------------------------------------------------------------------------
package histeq_pkg;

    // image geometry and gray scale
    localparam int IMAGE_HEIGHT = 256;
    localparam int IMAGE_WIDTH  = 256;
    localparam int GRAY_LEVELS  = 256;

    // pixel count of one image, a power of two
    localparam int PIXEL_COUNT = IMAGE_HEIGHT * IMAGE_WIDTH;
    localparam int PIX_LOG2    = $clog2(PIXEL_COUNT);
    localparam int TOP_LEVEL   = GRAY_LEVELS - 1;

    // widths
    localparam int PIX_W  = 8;
    localparam int LVL_W  = (GRAY_LEVELS > 1) ? $clog2(GRAY_LEVELS) : 1;
    localparam int CNT_W  = $clog2(PIXEL_COUNT + 1);
    localparam int PROD_W = CNT_W + PIX_W;

    typedef logic [PIX_W-1:0] pixel_t;
    typedef logic [LVL_W-1:0] level_t;
    typedef logic [CNT_W-1:0] count_t;

    localparam level_t LVL_TOP = level_t'(TOP_LEVEL);
    localparam count_t CNT_MAX = count_t'(PIXEL_COUNT);

    // bin memory control from the sequencer
    typedef struct packed {
        logic   acc_en;
        level_t acc_addr;
        logic   swp_en;
        level_t swp_addr;
        logic   clr_en;
        level_t clr_addr;
    } bin_ctl_t;

    // map table write port
    typedef struct packed {
        logic   en;
        level_t addr;
        pixel_t data;
    } map_wr_t;

    // pixel value saturated to the top gray level
    function automatic level_t clamp_level(input pixel_t p);
        level_t lvl;
        if (int'(p) > TOP_LEVEL)
            lvl = LVL_TOP;
        else
            lvl = level_t'(p);
        return lvl;
    endfunction

endpackage

// File: rtl/core/histeq_hist.sv
// ----------------------------------------------------------------------------
// histeq_hist
// Bin count memory with read-modify-write for accumulate transactions,
// a sweep read port for the table build and zero writes for clearing.
// ----------------------------------------------------------------------------
module histeq_hist (
    input  logic                clk,
    input  logic                rst_n,
    input  histeq_pkg::bin_ctl_t ctl,
    output histeq_pkg::count_t   rd_data
);
    import histeq_pkg::*;

    count_t mem [GRAY_LEVELS];
    count_t q_reg;
    count_t fwd_data_reg;
    logic   fwd_hit_reg;
    logic   s1_valid_reg;
    level_t s1_addr_reg;

    logic   we;
    level_t wa;
    count_t wd;
    logic   re;
    level_t ra;
    count_t rdata;
    count_t inc;

    // read data with write-to-read forwarding on same-edge collisions
    assign rdata   = fwd_hit_reg ? fwd_data_reg : q_reg;
    assign rd_data = rdata;

    // saturating increment of the bin in the modify stage
    assign inc = (rdata < CNT_MAX) ? rdata + count_t'(1) : rdata;

    // port selection
    assign we = s1_valid_reg | ctl.clr_en;
    assign wa = s1_valid_reg ? s1_addr_reg : ctl.clr_addr;
    assign wd = s1_valid_reg ? inc : '0;
    assign re = ctl.acc_en | ctl.swp_en;
    assign ra = ctl.acc_en ? ctl.acc_addr : ctl.swp_addr;

    // memory array
    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        if (re)
        begin
            q_reg        <= mem[ra];
            fwd_data_reg <= wd;
        end
    end

    // modify stage control and forward flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_addr_reg  <= '0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= ctl.acc_en;
            if (ctl.acc_en)
                s1_addr_reg <= ctl.acc_addr;
            if (re)
                fwd_hit_reg <= we && (wa == ra);
        end
    end

endmodule

// File: rtl/core/histeq_build.sv
// ----------------------------------------------------------------------------
// histeq_build
// Running sum over the swept bins and scaling of each sum to a gray level.
// ----------------------------------------------------------------------------
module histeq_build (
    input  logic               clk,
    input  logic               bld_valid,
    input  histeq_pkg::level_t bld_idx,
    input  histeq_pkg::count_t bin_data,
    output histeq_pkg::map_wr_t map_wr
);
    import histeq_pkg::*;

    count_t             run_reg;
    logic [CNT_W:0]     sum;
    count_t             run_sat;
    logic [PROD_W-1:0]  prod;
    pixel_t             entry;

    // running sum, restarted at the first bin, saturated at the pixel count
    assign sum     = (bld_idx == '0) ? {1'b0, bin_data}
                                     : {1'b0, run_reg} + {1'b0, bin_data};
    assign run_sat = (sum > {1'b0, CNT_MAX}) ? CNT_MAX : sum[CNT_W-1:0];

    // scale by the top level, divide by the power-of-two pixel count
    assign prod  = PROD_W'(run_sat) * PROD_W'(TOP_LEVEL);
    assign entry = pixel_t'(prod >> PIX_LOG2);

    // table write, entry zero forced to black
    assign map_wr.en   = bld_valid;
    assign map_wr.addr = bld_idx;
    assign map_wr.data = (bld_idx == '0) ? '0 : entry;

    always_ff @(posedge clk)
    begin
        if (bld_valid)
            run_reg <= run_sat;
    end

endmodule

// File: rtl/core/histeq_map.sv
// ----------------------------------------------------------------------------
// histeq_map
// Mapping table memory; its registered read data is the output register.
// ----------------------------------------------------------------------------
module histeq_map (
    input  logic                clk,
    input  logic                rst_n,
    input  histeq_pkg::map_wr_t  wr,
    input  logic                rd_en,
    input  histeq_pkg::level_t   rd_addr,
    output logic                slot_free,
    output logic                out_valid,
    input  logic                out_ready,
    output histeq_pkg::pixel_t   equalized_pixel
);
    import histeq_pkg::*;

    pixel_t mem [GRAY_LEVELS];
    pixel_t q_reg;
    logic   valid_reg;

    assign out_valid       = valid_reg;
    assign equalized_pixel = q_reg;
    assign slot_free       = !valid_reg || out_ready;

    // memory array
    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.addr] <= wr.data;
        if (rd_en)
            q_reg <= mem[rd_addr];
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (rd_en)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

endmodule

// File: rtl/core/histogram_equalizer_unit.sv
// ----------------------------------------------------------------------------
// histogram_equalizer_unit
// Two-pass 8-bit grayscale histogram equalization with a 256-bin histogram
// memory and a 256-entry mapping table memory.
//
//   channel | signals                             | direction
//   --------+-------------------------------------+----------
//   input   | in_valid in_ready command pixel     | in
//           | last_pixel                          |
//   output  | out_valid out_ready equalized_pixel | out
//
// Accumulate and map transactions are taken only while the output
// register is empty or being drained. The last accumulate transaction
// starts a table build that sweeps the bin memory one bin per cycle,
// with in_ready low until the build is done. After reset a clearing
// pass writes zero to both memories, also with in_ready low.
// Bin updates of back-to-back transactions to one bin use read forwarding.
// ----------------------------------------------------------------------------
module histogram_equalizer_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               command,
    input  histeq_pkg::pixel_t pixel,
    input  logic               last_pixel,
    output logic               out_valid,
    input  logic               out_ready,
    output histeq_pkg::pixel_t equalized_pixel
);
    import histeq_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_BUILD = 2'd2;
    localparam logic [1:0] ST_DRAIN = 2'd3;

    logic [1:0] state_reg, state_next;
    level_t     idx_reg, idx_next;
    logic       bld_v_reg, bld_v_next;
    level_t     bld_idx_reg, bld_idx_next;

    logic       accept;
    logic       acc_accept;
    logic       map_accept;
    level_t     level;
    logic       slot_free;
    bin_ctl_t   bin_ctl;
    count_t     bin_data;
    map_wr_t    bld_wr;
    map_wr_t    map_wr;

    // input handshake
    assign in_ready   = (state_reg == ST_IDLE) && slot_free;
    assign accept     = in_valid && in_ready;
    assign acc_accept = accept && !command;
    assign map_accept = accept && command;
    assign level      = clamp_level(pixel);

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        bld_v_next   = (state_reg == ST_BUILD);
        bld_idx_next = idx_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                idx_next = idx_reg + level_t'(1);
                if (idx_reg == LVL_TOP)
                begin
                    state_next = ST_IDLE;
                    idx_next   = '0;
                end
            end
            ST_IDLE:
            begin
                if (acc_accept && last_pixel)
                begin
                    state_next = ST_BUILD;
                    idx_next   = '0;
                end
            end
            ST_BUILD:
            begin
                idx_next = idx_reg + level_t'(1);
                if (idx_reg == LVL_TOP)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                state_next = ST_IDLE;
                idx_next   = '0;
            end
            default:
            begin
                state_next = ST_CLEAR;
                idx_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            idx_reg     <= '0;
            bld_v_reg   <= 1'b0;
            bld_idx_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            bld_v_reg   <= bld_v_next;
            bld_idx_reg <= bld_idx_next;
        end
    end

    // bin memory control
    always_comb
    begin
        bin_ctl.acc_en   = acc_accept;
        bin_ctl.acc_addr = level;
        bin_ctl.swp_en   = (state_reg == ST_BUILD);
        bin_ctl.swp_addr = idx_reg;
        bin_ctl.clr_en   = (state_reg == ST_CLEAR) || bld_v_reg;
        bin_ctl.clr_addr = (state_reg == ST_CLEAR) ? idx_reg : bld_idx_reg;
    end

    // table write: clearing pass or build
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            map_wr.en   = 1'b1;
            map_wr.addr = idx_reg;
            map_wr.data = '0;
        end
        else
        begin
            map_wr = bld_wr;
        end
    end

    histeq_hist u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (bin_ctl),
        .rd_data (bin_data)
    );

    histeq_build u_build (
        .clk       (clk),
        .bld_valid (bld_v_reg),
        .bld_idx   (bld_idx_reg),
        .bin_data  (bin_data),
        .map_wr    (bld_wr)
    );

    histeq_map u_map (
        .clk             (clk),
        .rst_n           (rst_n),
        .wr              (map_wr),
        .rd_en           (map_accept),
        .rd_addr         (level),
        .slot_free       (slot_free),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .equalized_pixel (equalized_pixel)
    );

`ifndef NO_ASSERTIONS
    // a result appears only after a map transaction
    a_out_from_map: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && command))
        else $error("output valid without a map transaction");

    // the last accumulate transaction starts the table build
    a_build_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !command && last_pixel) |=> (state_reg == ST_BUILD))
        else $error("table build did not start");

    // a held result blocks new transactions
    a_hold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("transaction taken while result is stalled");

    // table writes happen only while the input side is closed
    a_wr_closed: assert property (@(posedge clk) disable iff (!rst_n)
        map_wr.en |-> !in_ready)
        else $error("table written while accepting");
`endif

endmodule
